// ===== hw/rtl/hrs_pkg.sv =====
// Package: shared types, constants and state codes of the hybrid scheduler.
package hrs_pkg;

    localparam int MAX_TASKS = 16;
    localparam int AW        = $clog2(MAX_TASKS);
    localparam int CW        = $clog2(MAX_TASKS + 1);

    localparam logic       FN_ADD = 1'b0;
    localparam logic       FN_RUN = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic       REG_QUANTUM  = 1'b0;
    localparam logic       REG_RR_LIMIT = 1'b1;

    localparam logic [7:0]  QUANTUM_RST  = 8'd3;
    localparam logic [7:0]  RR_LIMIT_RST = 8'd4;
    localparam logic [15:0] FIRST_ID     = 16'd1;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] burst;
    } t_entry;

    typedef struct packed {
        logic [15:0] task_id;
        logic [15:0] amount_run;
        logic        was_round_robin;
        logic        finished;
        logic [1:0]  status;
    } t_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_HEAD,
        S_ADD_NEXT,
        S_ADD_CMP,
        S_SHIFT,
        S_SHIFT_WR,
        S_RUN_HEAD,
        S_REM,
        S_REM_WR,
        S_SCAN,
        S_SCAN_CMP,
        S_MOVE,
        S_MOVE_WR,
        S_DONE
    } t_state;

endpackage

// ===== hw/rtl/hrs_in_if.sv =====
// Interface: input channel of the scheduler (add or run request).
interface hrs_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [7:0]  priority_req;
    logic [15:0] burst;

    modport source (output valid, func, priority_req, burst, input ready);
    modport sink (input valid, func, priority_req, burst, output ready);
endinterface

// ===== hw/rtl/hrs_out_if.sv =====
// Interface: result channel of the scheduler.
interface hrs_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] task_id;
    logic [15:0] amount_run;
    logic        was_round_robin;
    logic        finished;
    logic [1:0]  status;

    modport source (output valid, task_id, amount_run, was_round_robin, finished, status,
                    input ready);
    modport sink (input valid, task_id, amount_run, was_round_robin, finished, status,
                  output ready);
endinterface

// ===== hw/rtl/hybrid_rr_fifo_scheduler.sv =====
// Top level: two-class task scheduler over one priority-ordered task list.
//
// Input channel i_in carries add (func 0: priority_req, burst) or run (func 1)
// requests; every transfer yields exactly one result on o_out.
// Registers: index 0 quantum, index 1 rr_limit, written through i_cfg_we,
// i_cfg_idx, i_cfg_data; the user writes them only while the block is idle,
// which the block itself does not enforce.
// The list sits in a single-port-read RAM; a small sequencer walks, shifts
// and compares entries one RAM read at a time.
// Empty run and full add skip the list and go straight to the result.
// i_in.ready is high only while the sequencer is idle. The result sits in an
// output register; a stalled receiver holds it, the next item may still be
// accepted, and its result waits until the register frees.
// Reset empties the list, sets the next id to 1, quantum 3, rr_limit 4.
module hybrid_rr_fifo_scheduler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrs_in_if.sink     i_in,
    hrs_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import hrs_pkg::*;

    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [15:0]     r_next_id, n_next_id;
    logic [7:0]      r_quantum, r_rr_limit;
    t_entry          r_ent, n_ent;
    logic [CW-1:0]   r_k, n_k;
    logic [CW-1:0]   r_cur, n_cur;
    logic [CW-1:0]   r_pos, n_pos;
    logic [7:0]      r_prev_prio, n_prev_prio;
    logic [7:0]      r_head_prio, n_head_prio;
    t_res            r_res, n_res;
    t_res            r_out, n_out;
    logic            r_out_valid, n_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [AW-1:0]   ram_raddr;
    t_entry          ram_wdata;
    t_entry          rd;

    logic            accept;
    logic            out_free;
    logic [CW-1:0]   k_m1, k_p1, cur_p1;
    logic [CW-1:0]   pos_calc;
    logic            walk_step;
    logic            is_fifo;
    logic            over_q;

    hrs_ram #(.WIDTH($bits(t_entry)), .DEPTH(MAX_TASKS)) u_list (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(rd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign out_free   = !r_out_valid || o_out.ready;
    assign k_m1       = r_k - CW'(1);
    assign k_p1       = r_k + CW'(1);
    assign cur_p1     = r_cur + CW'(1);
    assign pos_calc   = (r_cur == '0 && r_ent.prio < r_head_prio) ? '0 : cur_p1;
    assign walk_step  = (rd.prio == r_prev_prio) || (rd.prio <= r_ent.prio);
    assign is_fifo    = rd.prio > r_rr_limit;
    assign over_q     = rd.burst > {8'd0, r_quantum};

    assign o_out.valid           = r_out_valid;
    assign o_out.task_id         = r_out.task_id;
    assign o_out.amount_run      = r_out.amount_run;
    assign o_out.was_round_robin = r_out.was_round_robin;
    assign o_out.finished        = r_out.finished;
    assign o_out.status          = r_out.status;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.func == FN_ADD) begin
                        if (r_count >= CW'(MAX_TASKS)) n_state = S_DONE;
                        else if (r_count == '0)        n_state = S_SHIFT;
                        else                           n_state = S_ADD_HEAD;
                    end else begin
                        n_state = (r_count == '0) ? S_DONE : S_RUN_HEAD;
                    end
                end
            end
            S_ADD_HEAD: n_state = S_ADD_NEXT;
            S_ADD_NEXT: n_state = (cur_p1 < r_count) ? S_ADD_CMP : S_SHIFT;
            S_ADD_CMP:  n_state = walk_step ? S_ADD_NEXT : S_SHIFT;
            S_SHIFT:    n_state = (r_k > r_pos) ? S_SHIFT_WR : S_DONE;
            S_SHIFT_WR: n_state = S_SHIFT;
            S_RUN_HEAD: n_state = (!is_fifo && over_q) ? S_SCAN : S_REM;
            S_REM:      n_state = (r_k < r_count) ? S_REM_WR : S_DONE;
            S_REM_WR:   n_state = S_REM;
            S_SCAN:     n_state = (r_k < r_count) ? S_SCAN_CMP : S_MOVE;
            S_SCAN_CMP: n_state = S_SCAN;
            S_MOVE:     n_state = (r_k < r_cur) ? S_MOVE_WR : S_DONE;
            S_MOVE_WR:  n_state = S_MOVE;
            S_DONE:     n_state = out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_next_id   = r_next_id;
        n_ent       = r_ent;
        n_k         = r_k;
        n_cur       = r_cur;
        n_pos       = r_pos;
        n_prev_prio = r_prev_prio;
        n_head_prio = r_head_prio;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = (r_out_valid && !o_out.ready);
        ram_we      = 1'b0;
        ram_waddr   = '0;
        ram_wdata   = r_ent;
        ram_raddr   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_in.func == FN_ADD) begin
                        if (r_count >= CW'(MAX_TASKS)) begin
                            n_res = '{16'd0, 16'd0, 1'b0, 1'b0, ST_FULL};
                        end else begin
                            n_ent     = '{r_next_id, i_in.priority_req, i_in.burst};
                            n_next_id = r_next_id + 16'd1;
                            n_pos     = '0;
                            n_k       = '0;
                        end
                    end else if (r_count == '0) begin
                        n_res = '{16'd0, 16'd0, 1'b0, 1'b0, ST_EMPTY};
                    end
                end
            end
            S_ADD_HEAD: begin
                n_head_prio = rd.prio;
                n_prev_prio = rd.prio;
                n_cur       = '0;
            end
            S_ADD_NEXT: begin
                ram_raddr = cur_p1[AW-1:0];
                if (!(cur_p1 < r_count)) begin
                    n_pos = pos_calc;
                    n_k   = r_count;
                end
            end
            S_ADD_CMP: begin
                if (walk_step) begin
                    n_cur       = cur_p1;
                    n_prev_prio = rd.prio;
                end else begin
                    n_pos = pos_calc;
                    n_k   = r_count;
                end
            end
            S_SHIFT: begin
                ram_raddr = k_m1[AW-1:0];
                if (!(r_k > r_pos)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_pos[AW-1:0];
                    ram_wdata = r_ent;
                    n_count   = r_count + CW'(1);
                    n_res     = '{r_ent.id, 16'd0, 1'b0, 1'b0, ST_OK};
                end
            end
            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = rd;
                n_k       = k_m1;
            end
            S_RUN_HEAD: begin
                n_k = CW'(1);
                if (is_fifo) begin
                    n_res = '{rd.id, rd.burst, 1'b0, 1'b1, ST_OK};
                end else if (over_q) begin
                    n_res       = '{rd.id, {8'd0, r_quantum}, 1'b1, 1'b0, ST_OK};
                    n_ent       = rd;
                    n_ent.burst = rd.burst - {8'd0, r_quantum};
                    n_cur       = '0;
                end else begin
                    n_res = '{rd.id, rd.burst, 1'b1, 1'b1, ST_OK};
                end
            end
            S_REM: begin
                ram_raddr = r_k[AW-1:0];
                if (!(r_k < r_count)) begin
                    n_count = r_count - CW'(1);
                end
            end
            S_REM_WR: begin
                ram_we    = 1'b1;
                ram_waddr = k_m1[AW-1:0];
                ram_wdata = rd;
                n_k       = k_p1;
            end
            S_SCAN: begin
                ram_raddr = r_k[AW-1:0];
                if (!(r_k < r_count)) begin
                    n_k = '0;
                end
            end
            S_SCAN_CMP: begin
                if (rd.prio <= r_rr_limit) begin
                    n_cur = r_k;
                end
                n_k = k_p1;
            end
            S_MOVE: begin
                ram_raddr = k_p1[AW-1:0];
                if (!(r_k < r_cur)) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cur[AW-1:0];
                    ram_wdata = r_ent;
                end
            end
            S_MOVE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = r_k[AW-1:0];
                ram_wdata = rd;
                n_k       = k_p1;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                end
            end
            default: begin
                n_k = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_next_id   <= FIRST_ID;
            r_out_valid <= 1'b0;
            r_quantum   <= QUANTUM_RST;
            r_rr_limit  <= RR_LIMIT_RST;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_next_id   <= n_next_id;
            r_out_valid <= n_out_valid;
            if (i_cfg_we && i_cfg_idx == REG_QUANTUM) begin
                r_quantum <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_idx == REG_RR_LIMIT) begin
                r_rr_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent       <= n_ent;
        r_k         <= n_k;
        r_cur       <= n_cur;
        r_pos       <= n_pos;
        r_prev_prio <= n_prev_prio;
        r_head_prio <= n_head_prio;
        r_res       <= n_res;
        r_out       <= n_out;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_TASKS))
        else $error("task count above capacity");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_count == $past(r_count) || r_count == $past(r_count) + CW'(1)
                  || r_count + CW'(1) == $past(r_count)))
        else $error("task count moved by more than one");

    a_id_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_next_id != $past(r_next_id)) |-> (r_next_id == $past(r_next_id) + 16'd1))
        else $error("next id skipped");

    a_empty_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status == ST_EMPTY) |-> (r_out.task_id == 16'd0))
        else $error("empty run reported a task");

endmodule

// ===== hw/rtl/hrs_ram.sv =====
// Generic simple dual-port RAM with registered read.
module hrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
